### rtl/pse_pkg.sv
// ----------------------------------------------------------------------------
// pse_pkg
// Shared sizes, codes and control structs of the prime sieve engine.
// ----------------------------------------------------------------------------
package pse_pkg;

   // bitmap size and derived widths
   localparam int MAP_DEPTH = 65536;
   localparam int ADDR_W    = $clog2(MAP_DEPTH);
   localparam int LIMIT_W   = 16;
   localparam int WIDE_W    = ((ADDR_W > LIMIT_W) ? ADDR_W : LIMIT_W) + 1;
   localparam int P_W       = (ADDR_W + 1) / 2 + 1;
   localparam int SQ_W      = 2 * P_W;
   localparam int M_W       = ADDR_W + 3;
   localparam int COUNT_W   = 13;

   // register reset and first candidate
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(100);
   localparam int                 FIRST_PRIME = 2;

   // request command codes
   localparam logic CMD_RUN   = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   // controller to datapath
   typedef struct packed {
      logic run_start;
      logic query_start;
      logic init_step;
      logic p_start;
      logic sq_load;
      logic p_read;
      logic m_load;
      logic strike;
      logic p_next;
      logic count_start;
      logic count_step;
      logic commit;
      logic load_rsp;
   } pse_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic init_last;
      logic sq_over;
      logic rd_bit;
      logic m_over;
      logic count_last;
   } pse_sts_type;

endpackage

### rtl/pse_if.sv
// ----------------------------------------------------------------------------
// pse channel interfaces
// Valid/ready channels for requests, responses and the limit register write.
// ----------------------------------------------------------------------------
interface pse_req_if;
   import pse_pkg::*;
   logic               valid;
   logic               ready;
   logic               command;
   logic [LIMIT_W-1:0] value;

   modport source (output valid, output command, output value, input ready);
   modport sink   (input valid, input command, input value, output ready);
endinterface

interface pse_rsp_if;
   import pse_pkg::*;
   logic               valid;
   logic               ready;
   logic               is_prime;
   logic [COUNT_W-1:0] prime_count;
   logic               sieved;

   modport source (output valid, output is_prime, output prime_count, output sieved,
                   input ready);
   modport sink   (input valid, input is_prime, input prime_count, input sieved,
                   output ready);
endinterface

interface pse_csr_if;
   import pse_pkg::*;
   logic               valid;
   logic               ready;
   logic [LIMIT_W-1:0] wdata;

   modport source (output valid, output wdata, input ready);
   modport sink   (input valid, input wdata, output ready);
endinterface

### rtl/prime_sieve_engine_core.sv
// ----------------------------------------------------------------------------
// prime_sieve_engine_core
// Sieve of Eratosthenes over a one-bit prime map with run and query requests.
// ----------------------------------------------------------------------------
//  channel | dir | handshake     | payload
//  req_ch  | in  | valid / ready | command, value
//  rsp_ch  | out | valid / ready | is_prime, prime_count, sieved
//  csr_ch  | in  | valid / ready | wdata (limit), always ready
//
//  a query's response is registered in ST_RESULT, off the registered read of
//  the map memory, and no new request is taken until it leaves ST_RESULT.
//  a run does the fill sweep, then for each base up to sqrt(top) the square,
//  check and read steps and one write per struck multiple, then the loop
//  exit, count sweep, count tail and response, all on the single map write
//  port. one request is in work at a time; a waiting response holds the
//  controller until taken.
//  reset is synchronous; the map needs no clearing pass, each run rewrites it.
// ----------------------------------------------------------------------------
module prime_sieve_engine_core (
   input  logic       clock,
   input  logic       reset,
   pse_req_if.sink    req_ch,
   pse_rsp_if.source  rsp_ch,
   pse_csr_if.sink    csr_ch
);
   import pse_pkg::*;

   pse_cmd_type cmd;
   pse_sts_type sts;
   logic        csr_write;

   // limit register is always writable
   assign csr_ch.ready = 1'b1;
   assign csr_write    = csr_ch.valid && csr_ch.ready;

   // sequencer
   pse_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_ch.valid),
      .req_command (req_ch.command),
      .req_ready   (req_ch.ready),
      .rsp_ready   (rsp_ch.ready),
      .rsp_valid   (rsp_ch.valid),
      .sts         (sts),
      .cmd         (cmd)
   );

   // map and counters
   pse_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .csr_write       (csr_write),
      .csr_wdata       (csr_ch.wdata),
      .req_value       (req_ch.value),
      .rsp_is_prime    (rsp_ch.is_prime),
      .rsp_prime_count (rsp_ch.prime_count),
      .rsp_sieved      (rsp_ch.sieved)
   );

endmodule

### rtl/pse_ctrl.sv
// ----------------------------------------------------------------------------
// pse_ctrl
// Sequencer for run and query requests and owner of the response valid.
// ----------------------------------------------------------------------------
module pse_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_command,
   output logic                 req_ready,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   input  pse_pkg::pse_sts_type sts,
   output pse_pkg::pse_cmd_type cmd
);
   import pse_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INIT,
      ST_P_SQ,
      ST_P_CHECK,
      ST_P_WAIT,
      ST_STRIKE,
      ST_COUNT,
      ST_COUNT_TAIL,
      ST_RESULT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;
   logic      rsp_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign accept    = req_valid && req_ready;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_command == CMD_QUERY) begin
                  cmd.query_start = 1'b1;
               end else begin
                  cmd.run_start = 1'b1;
               end
               state_in = (req_command == CMD_QUERY) ? ST_RESULT : ST_INIT;
            end
         end
         ST_INIT: begin
            cmd.init_step = 1'b1;
            if (sts.init_last) begin
               cmd.p_start = 1'b1;
               state_in    = ST_P_SQ;
            end
         end
         ST_P_SQ: begin
            cmd.sq_load = 1'b1;
            state_in    = ST_P_CHECK;
         end
         ST_P_CHECK: begin
            if (sts.sq_over) begin
               cmd.count_start = 1'b1;
               state_in        = ST_COUNT;
            end else begin
               cmd.p_read = 1'b1;
               state_in   = ST_P_WAIT;
            end
         end
         ST_P_WAIT: begin
            if (sts.rd_bit) begin
               cmd.m_load = 1'b1;
               state_in   = ST_STRIKE;
            end else begin
               cmd.p_next = 1'b1;
               state_in   = ST_P_SQ;
            end
         end
         ST_STRIKE: begin
            if (sts.m_over) begin
               cmd.p_next = 1'b1;
               state_in   = ST_P_SQ;
            end else begin
               cmd.strike = 1'b1;
            end
         end
         ST_COUNT: begin
            cmd.count_step = 1'b1;
            if (sts.count_last) begin
               state_in = ST_COUNT_TAIL;
            end
         end
         ST_COUNT_TAIL: begin
            // last read bit is added at this edge
            cmd.commit = 1'b1;
            state_in   = ST_RESULT;
         end
         ST_RESULT: begin
            if (rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = cmd.load_rsp || (rsp_valid_ff && !rsp_ready);

   // state and response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

### rtl/pse_datapath.sv
// ----------------------------------------------------------------------------
// pse_datapath
// Prime bitmap memory, sieve counters, limit register and response payload.
// ----------------------------------------------------------------------------
module pse_datapath (
   input  logic                         clock,
   input  logic                         reset,
   input  pse_pkg::pse_cmd_type         cmd,
   output pse_pkg::pse_sts_type         sts,
   input  logic                         csr_write,
   input  logic [pse_pkg::LIMIT_W-1:0]  csr_wdata,
   input  logic [pse_pkg::LIMIT_W-1:0]  req_value,
   output logic                         rsp_is_prime,
   output logic [pse_pkg::COUNT_W-1:0]  rsp_prime_count,
   output logic                         rsp_sieved
);
   import pse_pkg::*;

   // bitmap
   logic map_mem [MAP_DEPTH];
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic              rd_data_ff;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic              wr_data;

   // control state
   logic [LIMIT_W-1:0] limit_ff;
   logic [ADDR_W-1:0]  sieved_limit_ff;
   logic [COUNT_W-1:0] found_count_ff, found_count_in;
   logic               run_done_ff;
   logic               pend_ff;

   // working registers
   logic [ADDR_W-1:0]  top_ff, top_in;
   logic [ADDR_W-1:0]  k_ff, k_in;
   logic [P_W-1:0]     p_ff, p_in;
   logic [M_W-1:0]     sq_ff;
   logic [M_W-1:0]     m_ff, m_in;
   logic               is_query_ff;
   logic               q_ok_ff, q_ok_in;
   logic               rsp_is_prime_ff;
   logic [COUNT_W-1:0] rsp_prime_count_ff;
   logic               rsp_sieved_ff;

   logic [WIDE_W-1:0]  limit_wide;
   logic [WIDE_W-1:0]  value_wide;
   logic [M_W-1:0]     top_m;

   assign limit_wide = WIDE_W'(limit_ff);
   assign value_wide = WIDE_W'(req_value);
   assign top_m      = M_W'(top_ff);

   // run limit saturated to the map
   always_comb begin
      if (limit_wide > WIDE_W'(MAP_DEPTH - 1)) begin
         top_in = ADDR_W'(MAP_DEPTH - 1);
      end else begin
         top_in = limit_wide[ADDR_W-1:0];
      end
   end

   // query is answered from the map only inside the last sieved range
   assign q_ok_in = run_done_ff && (value_wide >= WIDE_W'(FIRST_PRIME)) &&
                    (value_wide <= WIDE_W'(sieved_limit_ff));

   // counter next values
   assign k_in = (cmd.run_start || cmd.count_start) ? '0 : k_ff + 1'b1;
   assign p_in = cmd.p_start ? P_W'(FIRST_PRIME) : p_ff + 1'b1;
   assign m_in = cmd.m_load ? sq_ff : m_ff + M_W'(p_ff);
   assign found_count_in = found_count_ff + COUNT_W'(rd_data_ff);

   // status to the controller
   assign sts.init_last  = (k_ff == top_ff);
   assign sts.count_last = (k_ff == top_ff);
   assign sts.sq_over    = (sq_ff > top_m);
   assign sts.m_over     = (m_ff > top_m);
   assign sts.rd_bit     = rd_data_ff;

   // memory port selection
   always_comb begin
      rd_en   = cmd.query_start || cmd.p_read || cmd.count_step;
      rd_addr = k_ff;
      priority if (cmd.query_start) begin
         rd_addr = value_wide[ADDR_W-1:0];
      end else if (cmd.p_read) begin
         rd_addr = ADDR_W'(p_ff);
      end else begin
         rd_addr = k_ff;
      end
   end

   always_comb begin
      wr_en = cmd.init_step || cmd.strike;
      if (cmd.strike) begin
         wr_addr = m_ff[ADDR_W-1:0];
         wr_data = 1'b0;
      end else begin
         wr_addr = k_ff;
         wr_data = (k_ff >= ADDR_W'(FIRST_PRIME));
      end
   end

   // bitmap write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         map_mem[wr_addr] <= wr_data;
      end
   end

   // bitmap registered read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= map_mem[rd_addr];
      end
   end

   // limit register, run results and count accumulator
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff        <= LIMIT_RESET;
         sieved_limit_ff <= '0;
         found_count_ff  <= '0;
         run_done_ff     <= 1'b0;
         pend_ff         <= 1'b0;
      end else begin
         if (csr_write) begin
            limit_ff <= csr_wdata;
         end
         if (cmd.commit) begin
            sieved_limit_ff <= top_ff;
            run_done_ff     <= 1'b1;
         end
         if (cmd.run_start) begin
            found_count_ff <= '0;
         end else if (pend_ff) begin
            found_count_ff <= found_count_in;
         end
         pend_ff <= cmd.count_step;
      end
   end

   // sieve walk registers
   always_ff @(posedge clock) begin
      if (cmd.run_start) begin
         top_ff <= top_in;
      end
      if (cmd.run_start || cmd.init_step || cmd.count_start || cmd.count_step) begin
         k_ff <= k_in;
      end
      if (cmd.p_start || cmd.p_next) begin
         p_ff <= p_in;
      end
      if (cmd.sq_load) begin
         sq_ff <= M_W'(SQ_W'(p_ff) * SQ_W'(p_ff));
      end
      if (cmd.m_load || cmd.strike) begin
         m_ff <= m_in;
      end
   end

   // request kind and query qualifier
   always_ff @(posedge clock) begin
      if (cmd.query_start || cmd.run_start) begin
         is_query_ff <= cmd.query_start;
         q_ok_ff     <= q_ok_in;
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_is_prime_ff    <= is_query_ff && q_ok_ff && rd_data_ff;
         rsp_prime_count_ff <= found_count_ff;
         rsp_sieved_ff      <= run_done_ff;
      end
   end

   assign rsp_is_prime    = rsp_is_prime_ff;
   assign rsp_prime_count = rsp_prime_count_ff;
   assign rsp_sieved      = rsp_sieved_ff;

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the prime sieve engine. A queue of run and query
// requests feeds a clocked driver; each accepted run updates a local
// bitmap sieve, and each accepted request queues the response it should
// cause. A clocked monitor compares every response, field by field, with
// the oldest one queued. Both channels idle in random bursts, and the limit
// register is rewritten between phases, once all responses have come back.
// ----------------------------------------------------------------------------
module tb_top;
   import pse_pkg::*;

   typedef struct packed {
      logic               command;
      logic [LIMIT_W-1:0] value;
   } sieve_req_t;

   typedef struct packed {
      logic               is_prime;
      logic [COUNT_W-1:0] prime_count;
      logic               sieved;
   } verdict_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   pse_req_if req_bus ();
   pse_rsp_if rsp_bus ();
   pse_csr_if csr_bus ();

   prime_sieve_engine_core DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus),
      .csr_ch (csr_bus)
   );

   // local copy of the engine state
   logic [LIMIT_W-1:0] limit_shadow;
   bit                 prime_bits [MAP_DEPTH];
   int                 map_top;
   logic [COUNT_W-1:0] map_count;
   logic               map_valid;

   sieve_req_t sieve_requests [$];
   verdict_t   awaited_verdicts [$];
   sieve_req_t in_flight;

   int  issued;
   int  send_gap;
   int  stall_left;
   bit  idle_off;
   int  failures;
   int  runs_taken;
   int  queries_taken;
   int  primes_reported;
   int  widest_top;

   // clock
   always #1 clock = ~clock;

   // expected response for one accepted request
   function automatic verdict_t predict_verdict(sieve_req_t r);
      verdict_t v;
      int       top;
      int       k;
      int       p;
      int       m;
      int       total;
      v.is_prime = 1'b0;
      if (r.command == CMD_RUN) begin
         top = (int'(limit_shadow) > MAP_DEPTH - 1) ? MAP_DEPTH - 1 : int'(limit_shadow);
         for (k = 0; k <= top; k++)
            prime_bits[k] = (k >= FIRST_PRIME);
         // strike multiples of each surviving base by repeated addition
         for (p = FIRST_PRIME; p * p <= top; p++) begin
            if (prime_bits[p]) begin
               for (m = p * p; m <= top; m += p)
                  prime_bits[m] = 1'b0;
            end
         end
         total = 0;
         for (k = 0; k <= top; k++)
            total += prime_bits[k];
         map_top   = top;
         map_count = COUNT_W'(total);
         map_valid = 1'b1;
      end else if (map_valid && r.value >= FIRST_PRIME && int'(r.value) <= map_top) begin
         v.is_prime = prime_bits[r.value];
      end
      v.prime_count = map_count;
      v.sieved      = map_valid;
      return v;
   endfunction

   function automatic void queue_request(logic cmd, int val);
      sieve_requests.push_back('{command: cmd, value: LIMIT_W'(val)});
      issued++;
   endfunction

   // wait until every request has gone and every response has come back
   task automatic drain_requests();
      do @(negedge clock);
      while (sieve_requests.size() != 0 || req_bus.valid || awaited_verdicts.size() != 0);
   endtask

   task automatic write_limit(int lim);
      @(posedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.wdata <= LIMIT_W'(lim);
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      csr_bus.valid <= 1'b0;
      limit_shadow = LIMIT_W'(lim);
      if (lim > widest_top) widest_top = lim;
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            awaited_verdicts.push_back(predict_verdict(in_flight));
            if (in_flight.command == CMD_RUN) runs_taken++;
            else queries_taken++;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_bus.valid <= 1'b0;
            end else if (sieve_requests.size() == 0) begin
               req_bus.valid <= 1'b0;
            end else if (!idle_off && $urandom_range(0, 9) == 0) begin
               send_gap = $urandom_range(1, 18) - 1;
               req_bus.valid <= 1'b0;
            end else begin
               in_flight = sieve_requests.pop_front();
               req_bus.valid   <= 1'b1;
               req_bus.command <= in_flight.command;
               req_bus.value   <= in_flight.value;
            end
         end
      end
   end

   // response monitor and back-pressure
   always @(posedge clock) begin
      verdict_t want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (rsp_bus.is_prime) primes_reported++;
            if (awaited_verdicts.size() == 0) begin
               $error("response with no request outstanding");
               failures++;
            end else begin
               want = awaited_verdicts.pop_front();
               if (rsp_bus.is_prime !== want.is_prime) begin
                  $error("is_prime mismatch: expected %0d, got %0d",
                         want.is_prime, rsp_bus.is_prime);
                  failures++;
               end
               if (rsp_bus.prime_count !== want.prime_count) begin
                  $error("prime_count mismatch: expected %0d, got %0d",
                         want.prime_count, rsp_bus.prime_count);
                  failures++;
               end
               if (rsp_bus.sieved !== want.sieved) begin
                  $error("sieved mismatch: expected %0d, got %0d",
                         want.sieved, rsp_bus.sieved);
                  failures++;
               end
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else if (!idle_off && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(1, 18) - 1;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // stimulus
   initial begin
      int phase_len;
      int tier;
      int pick;
      int span;
      int lim;
      int n;
      req_bus.valid   = 1'b0;
      req_bus.command = CMD_RUN;
      req_bus.value   = '0;
      rsp_bus.ready   = 1'b0;
      csr_bus.valid   = 1'b0;
      csr_bus.wdata   = '0;
      limit_shadow    = LIMIT_RESET;
      map_top         = 0;
      map_count       = '0;
      map_valid       = 1'b0;
      widest_top      = int'(LIMIT_RESET);
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // queries before any run, then a run at the reset limit
      queue_request(CMD_QUERY, 0);
      queue_request(CMD_QUERY, 1);
      queue_request(CMD_QUERY, 2);
      queue_request(CMD_QUERY, 97);
      queue_request(CMD_QUERY, 65535);
      queue_request(CMD_RUN, 0);
      queue_request(CMD_QUERY, 97);
      queue_request(CMD_QUERY, 100);
      queue_request(CMD_QUERY, 101);
      queue_request(CMD_QUERY, 0);
      queue_request(CMD_QUERY, 1);
      queue_request(CMD_QUERY, 2);
      queue_request(CMD_QUERY, 4);
      drain_requests();

      // full-width sieve, queries at the top of the map
      write_limit(65535);
      queue_request(CMD_RUN, 65535);
      queue_request(CMD_QUERY, 65521);
      queue_request(CMD_QUERY, 65535);
      drain_requests();

      // new limit has no effect until the next run; then limits of zero, one and two
      write_limit(0);
      queue_request(CMD_QUERY, 65521);
      queue_request(CMD_RUN, 0);
      queue_request(CMD_QUERY, 0);
      queue_request(CMD_QUERY, 2);
      drain_requests();
      write_limit(1);
      queue_request(CMD_RUN, 1);
      queue_request(CMD_QUERY, 1);
      drain_requests();
      write_limit(2);
      queue_request(CMD_RUN, 2);
      queue_request(CMD_QUERY, 2);
      queue_request(CMD_QUERY, 3);
      drain_requests();

      // random phases, each usually behind a fresh limit and usually opened by a run
      n = 0;
      while (n < 2) begin
         if (issued >= 1320) begin
            idle_off = 1'b1;
            phase_len = 80;
            n = 2;
         end else begin
            idle_off = ($urandom_range(0, 4) == 0);
            phase_len = $urandom_range(20, 90);
         end
         if ($urandom_range(0, 99) < 85) begin
            tier = $urandom_range(0, 99);
            if (tier < 4) lim = $urandom_range(0, 3);
            else if (tier < 70) lim = $urandom_range(4, 300);
            else if (tier < 95) lim = $urandom_range(301, 3000);
            else lim = $urandom_range(3001, 8000);
            write_limit(lim);
         end
         if ($urandom_range(0, 9) != 0) begin
            queue_request(CMD_RUN, $urandom_range(0, 65535));
            phase_len--;
         end
         span = (int'(limit_shadow) > 65532) ? 65535 : int'(limit_shadow) + 3;
         repeat (phase_len) begin
            pick = $urandom_range(0, 99);
            if (pick < 5) queue_request(CMD_RUN, $urandom_range(0, 65535));
            else if (pick < 20) queue_request(CMD_QUERY, $urandom_range(0, 65535));
            else queue_request(CMD_QUERY, $urandom_range(0, span));
         end
         // pause the sender until every response is back
         drain_requests();
      end

      repeat (20) @(posedge clock);
      $display("ran %0d sieves and %0d queries, %0d responses reported prime",
               runs_taken, queries_taken, primes_reported);
      $display("limit settings reached up to %0d, including 0, 1 and the full map",
               widest_top);
      if (failures == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // watchdog
   initial begin
      #100_000_000;
      $display("timeout with %0d requests queued and %0d responses outstanding",
               sieve_requests.size(), awaited_verdicts.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
